[rtl/core/itp_pkg.sv]
package itp_pkg;

    localparam int DEPTH_DEF   = 32;
    localparam int MAX_RESULTS = 32;
    localparam int NW          = $clog2(MAX_RESULTS + 1);

    typedef logic [2:0] t_code;

    localparam t_code CODE_NONE   = 3'd0;
    localparam t_code CODE_ADD    = 3'd1;
    localparam t_code CODE_SUB    = 3'd2;
    localparam t_code CODE_MUL    = 3'd3;
    localparam t_code CODE_DIV    = 3'd4;
    localparam t_code CODE_POW    = 3'd5;
    localparam t_code CODE_LPAREN = 3'd6;

    localparam logic [7:0] CH_ADD    = 8'h2B;
    localparam logic [7:0] CH_SUB    = 8'h2D;
    localparam logic [7:0] CH_MUL    = 8'h2A;
    localparam logic [7:0] CH_DIV    = 8'h2F;
    localparam logic [7:0] CH_POW    = 8'h5E;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;

    typedef logic [3:0] t_step;

    localparam t_step ST_FETCH  = 4'd0;
    localparam t_step ST_PASS   = 4'd1;
    localparam t_step ST_PUSH   = 4'd2;
    localparam t_step ST_OPOP   = 4'd3;
    localparam t_step ST_OEND   = 4'd4;
    localparam t_step ST_RPOP   = 4'd5;
    localparam t_step ST_RCLOSE = 4'd6;
    localparam t_step ST_FPOP   = 4'd7;
    localparam t_step ST_FEND   = 4'd8;

    typedef enum logic [2:0] {
        C_ALWAYS = 3'd0,
        C_INPUT  = 3'd1,
        C_OPLOOP = 3'd2,
        C_RLOOP  = 3'd3,
        C_FLOOP  = 3'd4
    } t_cond;

    typedef enum logic [2:0] {
        A_NONE     = 3'd0,
        A_LATCH    = 3'd1,
        A_EMIT_SYM = 3'd2,
        A_PUSH     = 3'd3,
        A_POP      = 3'd4,
        A_END_OP   = 3'd5,
        A_END_R    = 3'd6,
        A_END_F    = 3'd7
    } t_act;

    typedef struct packed {
        t_cond cond;
        t_act  act;
        logic  disp;
        t_step nxt_t;
        t_step nxt_f;
    } t_uword;

    typedef struct packed {
        t_act act;
        logic fire;
    } t_ctrl;

    typedef struct packed {
        logic  op_loop;
        logic  r_loop;
        logic  f_loop;
        logic  hold;
        t_step disp;
    } t_status;

    function automatic t_code op_code(input logic [7:0] c);
        t_code r;
        case (c)
            CH_ADD:  r = CODE_ADD;
            CH_SUB:  r = CODE_SUB;
            CH_MUL:  r = CODE_MUL;
            CH_DIV:  r = CODE_DIV;
            CH_POW:  r = CODE_POW;
            default: r = CODE_NONE;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] code_char(input t_code c);
        logic [7:0] r;
        case (c)
            CODE_ADD:    r = CH_ADD;
            CODE_SUB:    r = CH_SUB;
            CODE_MUL:    r = CH_MUL;
            CODE_DIV:    r = CH_DIV;
            CODE_POW:    r = CH_POW;
            CODE_LPAREN: r = CH_LPAREN;
            default:     r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] code_prec(input t_code c);
        logic [1:0] r;
        case (c)
            CODE_ADD: r = 2'd1;
            CODE_SUB: r = 2'd1;
            CODE_MUL: r = 2'd2;
            CODE_DIV: r = 2'd2;
            CODE_POW: r = 2'd3;
            default:  r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic t_step dispatch(input logic [7:0] c, input logic eoe);
        t_step r;
        if (eoe) begin
            r = ST_FPOP;
        end else if (is_alnum(c)) begin
            r = ST_PASS;
        end else if (c == CH_LPAREN) begin
            r = ST_PUSH;
        end else if (c == CH_RPAREN) begin
            r = ST_RPOP;
        end else if (op_code(c) != CODE_NONE) begin
            r = ST_OPOP;
        end else begin
            r = ST_FETCH;
        end
        return r;
    endfunction

    // control store
    function automatic t_uword ucode(input t_step s);
        t_uword w;
        case (s)
            ST_FETCH:  w = '{C_INPUT,  A_LATCH,    1'b1, ST_FETCH, ST_FETCH};
            ST_PASS:   w = '{C_ALWAYS, A_EMIT_SYM, 1'b0, ST_FETCH, ST_FETCH};
            ST_PUSH:   w = '{C_ALWAYS, A_PUSH,     1'b0, ST_FETCH, ST_FETCH};
            ST_OPOP:   w = '{C_OPLOOP, A_POP,      1'b0, ST_OPOP,  ST_OEND};
            ST_OEND:   w = '{C_ALWAYS, A_END_OP,   1'b0, ST_PUSH,  ST_PUSH};
            ST_RPOP:   w = '{C_RLOOP,  A_POP,      1'b0, ST_RPOP,  ST_RCLOSE};
            ST_RCLOSE: w = '{C_ALWAYS, A_END_R,    1'b0, ST_FETCH, ST_FETCH};
            ST_FPOP:   w = '{C_FLOOP,  A_POP,      1'b0, ST_FPOP,  ST_FEND};
            ST_FEND:   w = '{C_ALWAYS, A_END_F,    1'b0, ST_FETCH, ST_FETCH};
            default:   w = '{C_ALWAYS, A_NONE,     1'b0, ST_FETCH, ST_FETCH};
        endcase
        return w;
    endfunction

endpackage

[rtl/core/itp_ram.sv]
module itp_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/itp_seq.sv]
module itp_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  itp_pkg::t_status i_status,
    output itp_pkg::t_ctrl   o_ctrl,
    output logic             o_stall
);
    import itp_pkg::*;

    t_step  r_pc;
    t_step  n_pc;
    t_uword uw;
    logic   cond_ok;

    always_comb begin
        uw = ucode(r_pc);
        case (uw.cond)
            C_ALWAYS: cond_ok = 1'b1;
            C_INPUT:  cond_ok = i_valid;
            C_OPLOOP: cond_ok = i_status.op_loop;
            C_RLOOP:  cond_ok = i_status.r_loop;
            C_FLOOP:  cond_ok = i_status.f_loop;
            default:  cond_ok = 1'b0;
        endcase

        if (cond_ok && i_status.hold) begin
            n_pc = r_pc;
        end else if (cond_ok) begin
            n_pc = uw.disp ? i_status.disp : uw.nxt_t;
        end else begin
            n_pc = uw.nxt_f;
        end

        o_ctrl.act  = uw.act;
        o_ctrl.fire = cond_ok && !i_status.hold;
    end

    assign o_stall = (r_pc != ST_FETCH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= ST_FETCH;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

[rtl/core/itp_dp.sv]
module itp_dp #(
    parameter int DEPTH = itp_pkg::DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [7:0]       i_symbol,
    input  logic             i_end_of_expression,
    input  itp_pkg::t_ctrl   i_ctrl,
    output itp_pkg::t_status o_status,
    input  logic             i_stall,
    output logic             o_valid,
    output logic [7:0]       o_out_symbol,
    output logic             o_has_symbol,
    output logic             o_last_of_run,
    output logic             o_expression_done,
    output logic             o_overflow_seen
);
    import itp_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [7:0]    r_sym, n_sym;
    t_code         r_code, n_code;
    logic [CW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;
    t_code         r_top, n_top;
    logic          r_reload, n_reload;
    logic          r_pend_v, n_pend_v;
    t_code         r_pend, n_pend;
    logic [NW-1:0] r_n, n_n;

    logic          r_ov;
    logic [7:0]    r_osym;
    logic          r_ohas, r_olast, r_odone, r_oovf;

    logic          emit;
    logic [7:0]    e_sym;
    logic          e_has, e_last, e_done, e_ovf;

    logic          we;
    logic [CW-1:0] rd_ptr;
    t_code         rd_data;
    t_code         top_code;
    logic          nz, cap, full, out_free, need_out;

    assign top_code = r_reload ? rd_data : r_top;
    assign nz       = (r_count != '0);
    assign cap      = (r_n != NW'(MAX_RESULTS));
    assign full     = (r_count == CW'(DEPTH));
    assign out_free = !r_ov || !i_stall;

    always_comb begin
        case (i_ctrl.act)
            A_EMIT_SYM: need_out = 1'b1;
            A_END_F:    need_out = 1'b1;
            A_POP:      need_out = r_pend_v;
            A_END_OP:   need_out = r_pend_v;
            A_END_R:    need_out = r_pend_v;
            default:    need_out = 1'b0;
        endcase
    end

    assign o_status.op_loop = nz && cap && (code_prec(top_code) >= code_prec(r_code));
    assign o_status.r_loop  = nz && cap && (top_code != CODE_LPAREN);
    assign o_status.f_loop  = nz && cap;
    assign o_status.hold    = need_out && !out_free;
    assign o_status.disp    = dispatch(i_symbol, i_end_of_expression);

    always_comb begin
        n_sym    = r_sym;
        n_code   = r_code;
        n_count  = r_count;
        n_ovf    = r_ovf;
        n_top    = top_code;
        n_reload = 1'b0;
        n_pend_v = r_pend_v;
        n_pend   = r_pend;
        n_n      = r_n;
        we       = 1'b0;
        emit     = 1'b0;
        e_sym    = 8'h00;
        e_has    = 1'b0;
        e_last   = 1'b0;
        e_done   = 1'b0;
        e_ovf    = 1'b0;

        if (i_ctrl.fire) begin
            case (i_ctrl.act)
                A_LATCH: begin
                    n_sym    = i_symbol;
                    n_code   = (i_symbol == CH_LPAREN) ? CODE_LPAREN : op_code(i_symbol);
                    n_n      = '0;
                    n_pend_v = 1'b0;
                end
                A_EMIT_SYM: begin
                    emit   = 1'b1;
                    e_sym  = r_sym;
                    e_has  = 1'b1;
                    e_last = 1'b1;
                end
                A_PUSH: begin
                    if (full) begin
                        n_ovf = 1'b1;
                    end else begin
                        we      = 1'b1;
                        n_count = r_count + CW'(1);
                        n_top   = r_code;
                    end
                end
                A_POP: begin
                    if (r_pend_v) begin
                        emit  = 1'b1;
                        e_sym = code_char(r_pend);
                        e_has = 1'b1;
                    end
                    n_pend   = top_code;
                    n_pend_v = 1'b1;
                    n_count  = r_count - CW'(1);
                    n_n      = r_n + NW'(1);
                    n_reload = 1'b1;
                end
                A_END_OP: begin
                    if (r_pend_v) begin
                        emit   = 1'b1;
                        e_sym  = code_char(r_pend);
                        e_has  = 1'b1;
                        e_last = 1'b1;
                    end
                    n_pend_v = 1'b0;
                end
                A_END_R: begin
                    if (r_pend_v) begin
                        emit   = 1'b1;
                        e_sym  = code_char(r_pend);
                        e_has  = 1'b1;
                        e_last = 1'b1;
                    end
                    n_pend_v = 1'b0;
                    // drop the matching open paren
                    if (nz && (top_code == CODE_LPAREN)) begin
                        n_count  = r_count - CW'(1);
                        n_reload = 1'b1;
                    end
                end
                A_END_F: begin
                    emit     = 1'b1;
                    e_sym    = r_pend_v ? code_char(r_pend) : 8'h00;
                    e_has    = r_pend_v;
                    e_last   = 1'b1;
                    e_done   = 1'b1;
                    e_ovf    = r_ovf;
                    n_count  = '0;
                    n_ovf    = 1'b0;
                    n_pend_v = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    assign rd_ptr = n_count - CW'(1);

    itp_ram #(
        .WIDTH ($bits(t_code)),
        .DEPTH (DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (r_code),
        .i_raddr (rd_ptr[AW-1:0]),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_reload <= 1'b0;
            r_pend_v <= 1'b0;
            r_n      <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_ovf    <= n_ovf;
            r_reload <= n_reload;
            r_pend_v <= n_pend_v;
            r_n      <= n_n;
            if (emit) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sym  <= n_sym;
        r_code <= n_code;
        r_top  <= n_top;
        r_pend <= n_pend;
        if (emit) begin
            r_osym  <= e_sym;
            r_ohas  <= e_has;
            r_olast <= e_last;
            r_odone <= e_done;
            r_oovf  <= e_ovf;
        end
    end

    assign o_valid           = r_ov;
    assign o_out_symbol      = r_osym;
    assign o_has_symbol      = r_ohas;
    assign o_last_of_run     = r_olast;
    assign o_expression_done = r_odone;
    assign o_overflow_seen   = r_oovf;

endmodule

[rtl/core/infix_to_postfix_converter.sv]
// a result is registered onto the output in the cycle after the microcode step that makes it
// an operator, ')' or the end marker pops the stack before its closing step; the sequencer
//   issues one stack pop per cycle while the output is not stalled
// one transaction in flight at a time, one step of the control store per cycle unless held
// reset: synchronous active low, clears the step counter, stack count, overflow flag
//   and output valid; stack contents are not cleared
module infix_to_postfix_converter #(
    parameter int DEPTH = itp_pkg::DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_symbol,
    input  logic       i_end_of_expression,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_symbol,
    output logic       o_has_symbol,
    output logic       o_last_of_run,
    output logic       o_expression_done,
    output logic       o_overflow_seen
);
    import itp_pkg::*;

    t_ctrl   ctrl;
    t_status status;

    itp_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (status),
        .o_ctrl   (ctrl),
        .o_stall  (o_stall)
    );

    itp_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_symbol            (i_symbol),
        .i_end_of_expression (i_end_of_expression),
        .i_ctrl              (ctrl),
        .o_status            (status),
        .i_stall             (i_stall),
        .o_valid             (o_valid),
        .o_out_symbol        (o_out_symbol),
        .o_has_symbol        (o_has_symbol),
        .o_last_of_run       (o_last_of_run),
        .o_expression_done   (o_expression_done),
        .o_overflow_seen     (o_overflow_seen)
    );

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    import itp_pkg::*;

    localparam int STACK_DEPTH = DEPTH_DEF;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_ITEMS = 350;
    localparam int MAX_WAIT = 17;
    localparam logic [7:0] OP_CHARS [5] = '{CH_ADD, CH_SUB, CH_MUL, CH_DIV, CH_POW};

    typedef struct packed {
        logic [7:0] symbol;
        logic       eoe;
    } t_infix_char;

    typedef struct packed {
        logic [7:0] out_symbol;
        logic       has_symbol;
        logic       last_of_run;
        logic       expression_done;
        logic       overflow_seen;
    } t_postfix_out;

    // shunting-yard predictor and the postfix characters still owed by the block
    class t_postfix_board;
        t_code        op_stack [STACK_DEPTH];
        int           stack_used;
        bit           dropped_push;
        t_postfix_out postfix_due [$];
        int           errors;

        function new();
            stack_used = 0;
            dropped_push = 0;
            errors = 0;
        endfunction

        function int waiting();
            return postfix_due.size();
        endfunction

        function t_code code_of(logic [7:0] c);
            case (c)
                CH_ADD:  return CODE_ADD;
                CH_SUB:  return CODE_SUB;
                CH_MUL:  return CODE_MUL;
                CH_DIV:  return CODE_DIV;
                CH_POW:  return CODE_POW;
                default: return CODE_NONE;
            endcase
        endfunction

        function int prec_of(t_code c);
            case (c)
                CODE_ADD, CODE_SUB: return 1;
                CODE_MUL, CODE_DIV: return 2;
                CODE_POW:           return 3;
                default:            return 0;
            endcase
        endfunction

        function logic [7:0] char_of(t_code c);
            case (c)
                CODE_ADD:    return CH_ADD;
                CODE_SUB:    return CH_SUB;
                CODE_MUL:    return CH_MUL;
                CODE_DIV:    return CH_DIV;
                CODE_POW:    return CH_POW;
                CODE_LPAREN: return CH_LPAREN;
                default:     return 8'h00;
            endcase
        endfunction

        function void emit(logic [7:0] sym, logic has, logic last, logic done, logic ovf);
            postfix_due.push_back('{sym, has, last, done, ovf});
        endfunction

        function void push_code(t_code c);
            if (stack_used >= STACK_DEPTH) begin
                dropped_push = 1;
            end else begin
                op_stack[stack_used] = c;
                stack_used++;
            end
        endfunction

        // pop k entries from the top, flagging the last one of the run
        function void pop_emit(int k);
            for (int i = 0; i < k; i++) begin
                emit(char_of(op_stack[stack_used - 1 - i]), 1'b1, i == k - 1, 1'b0, 1'b0);
            end
            stack_used -= k;
        endfunction

        function void take_infix(logic [7:0] c, logic eoe);
            int    k;
            t_code code;
            k = 0;
            code = code_of(c);
            if (eoe) begin
                k = (stack_used < MAX_RESULTS) ? stack_used : MAX_RESULTS;
                if (k == 0) begin
                    emit(8'h00, 1'b0, 1'b1, 1'b1, dropped_push);
                end else begin
                    for (int i = 0; i < k; i++) begin
                        emit(char_of(op_stack[stack_used - 1 - i]), 1'b1, i == k - 1,
                             i == k - 1, (i == k - 1) ? dropped_push : 1'b0);
                    end
                end
                stack_used = 0;
                dropped_push = 0;
            end else if ((c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
                         (c >= "a" && c <= "z")) begin
                emit(c, 1'b1, 1'b1, 1'b0, 1'b0);
            end else if (c == CH_LPAREN) begin
                push_code(CODE_LPAREN);
            end else if (c == CH_RPAREN) begin
                while (k < stack_used && k < MAX_RESULTS &&
                       op_stack[stack_used - 1 - k] != CODE_LPAREN) begin
                    k++;
                end
                pop_emit(k);
                if (stack_used > 0 && op_stack[stack_used - 1] == CODE_LPAREN) begin
                    stack_used--;
                end
            end else if (code != CODE_NONE) begin
                while (k < stack_used && k < MAX_RESULTS &&
                       prec_of(op_stack[stack_used - 1 - k]) >= prec_of(code)) begin
                    k++;
                end
                pop_emit(k);
                push_code(code);
            end
        endfunction

        function void cmp(string field, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                $display("%0t: %s expected %0h got %0h", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_postfix(t_postfix_out got);
            t_postfix_out want;
            if (postfix_due.size() == 0) begin
                $display("%0t: unexpected result sym %0h has %0b last %0b done %0b ovf %0b",
                         $time, got.out_symbol, got.has_symbol, got.last_of_run,
                         got.expression_done, got.overflow_seen);
                errors++;
            end else begin
                want = postfix_due.pop_front();
                cmp("out_symbol", want.out_symbol, got.out_symbol);
                cmp("has_symbol", 8'(want.has_symbol), 8'(got.has_symbol));
                cmp("last_of_run", 8'(want.last_of_run), 8'(got.last_of_run));
                cmp("expression_done", 8'(want.expression_done), 8'(got.expression_done));
                cmp("overflow_seen", 8'(want.overflow_seen), 8'(got.overflow_seen));
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [7:0] i_symbol = 8'h00;
    logic       i_end_of_expression = 1'b0;
    logic       i_stall = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_out_symbol;
    logic       o_has_symbol;
    logic       o_last_of_run;
    logic       o_expression_done;
    logic       o_overflow_seen;

    t_postfix_board board;
    t_infix_char    infix_stream [$];
    int             cycle_count;
    int             rx_hold = 0;
    bit             rx_quiet = 0;
    bit             tx_quiet = 0;

    infix_to_postfix_converter #(.DEPTH(STACK_DEPTH)) DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_symbol           (i_symbol),
        .i_end_of_expression(i_end_of_expression),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_out_symbol       (o_out_symbol),
        .o_has_symbol       (o_has_symbol),
        .o_last_of_run      (o_last_of_run),
        .o_expression_done  (o_expression_done),
        .o_overflow_seen    (o_overflow_seen)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic void add_char(logic [7:0] c, logic e);
        infix_stream.push_back('{c, e});
    endfunction

    function automatic logic [7:0] any_alnum();
        int k;
        k = $urandom_range(0, 61);
        if (k < 10) return 8'(8'h30 + k);
        if (k < 36) return 8'(8'h41 + k - 10);
        return 8'(8'h61 + k - 36);
    endfunction

    function automatic logic [7:0] any_op();
        return OP_CHARS[$urandom_range(0, 4)];
    endfunction

    // mostly well-formed expression, with stray bytes and sometimes left unbalanced
    function automatic void gen_expression();
        int open_cnt;
        int len;
        int r;
        bit need_operand;
        open_cnt = 0;
        need_operand = 1;
        len = $urandom_range(1, 16);
        repeat (len) begin
            r = $urandom_range(0, 99);
            if (r < 7) begin
                add_char(8'($urandom_range(0, 255)), 1'b0);
            end else if (need_operand) begin
                if (r < 30) begin
                    add_char(CH_LPAREN, 1'b0);
                    open_cnt++;
                end else begin
                    add_char(any_alnum(), 1'b0);
                    need_operand = 0;
                end
            end else if (open_cnt > 0 && r < 45) begin
                add_char(CH_RPAREN, 1'b0);
                open_cnt--;
            end else begin
                add_char(any_op(), 1'b0);
                need_operand = 1;
            end
        end
        if ($urandom_range(0, 4) != 0) begin
            if (need_operand) add_char(any_alnum(), 1'b0);
            repeat (open_cnt) add_char(CH_RPAREN, 1'b0);
        end
        add_char(8'($urandom_range(0, 255)), 1'b1);
    endfunction

    // nesting around the stack limit, so pushes can get dropped
    function automatic void gen_deep_nest();
        int n;
        n = $urandom_range(30, 36);
        repeat (n) begin
            add_char(CH_LPAREN, 1'b0);
            if ($urandom_range(0, 5) == 0) add_char(any_alnum(), 1'b0);
        end
        repeat ($urandom_range(1, 4)) begin
            add_char(any_op(), 1'b0);
            add_char(any_alnum(), 1'b0);
        end
        repeat ($urandom_range(0, n)) add_char(CH_RPAREN, 1'b0);
        add_char(8'($urandom_range(0, 255)), 1'b1);
    endfunction

    task automatic send_item(input t_infix_char item, input int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_symbol <= item.symbol;
        i_end_of_expression <= item.eoe;
        do @(posedge i_clk); while (o_stall);
        board.take_infix(item.symbol, item.eoe);
    endtask

    // result side with random stall
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                board.check_postfix('{o_out_symbol, o_has_symbol, o_last_of_run,
                                      o_expression_done, o_overflow_seen});
                if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
                rx_hold = rx_quiet ? 0 : $urandom_range(0, MAX_WAIT);
            end else if (rx_hold > 0) begin
                rx_hold--;
            end
            i_stall <= (rx_hold > 0);
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("infix_to_postfix_converter regression: fail");
        $finish;
    end

    initial begin
        string directed;
        int    gap;
        int    random_start;
        board = new();

        // close on empty stack, empty flush, ignored bytes
        add_char(CH_RPAREN, 1'b0);
        add_char(8'hFF, 1'b1);
        add_char(8'h00, 1'b0);
        add_char(8'h80, 1'b0);
        add_char(8'hFF, 1'b0);
        // all operators, equal precedence, parens, unmatched close
        directed = "a+Z*0^9^A/z-(b*))+c";
        for (int i = 0; i < directed.len(); i++) add_char(directed[i], 1'b0);
        add_char(8'h00, 1'b1);

        random_start = infix_stream.size();
        while (infix_stream.size() < random_start + RANDOM_ITEMS) begin
            if ($urandom_range(0, 15) == 0) gen_deep_nest();
            else gen_expression();
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (infix_stream[idx]) begin
            if (idx == infix_stream.size() / 2) begin
                i_valid <= 1'b0;
                do @(posedge i_clk); while (board.waiting() > 0);
            end
            gap = tx_quiet ? 0 : $urandom_range(0, MAX_WAIT);
            send_item(infix_stream[idx], gap);
            if (infix_stream[idx].eoe) tx_quiet = ($urandom_range(0, 3) == 0);
        end
        i_valid <= 1'b0;

        while (board.waiting() > 0) @(posedge i_clk);
        repeat (48) @(posedge i_clk);

        if (board.errors == 0 && board.waiting() == 0) begin
            $display("infix_to_postfix_converter regression: pass");
        end else begin
            $display("infix_to_postfix_converter regression: fail");
        end
        $finish;
    end

endmodule
